// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the quarter-wave sine PWM RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define QWSP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define QWSP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/qwsp_pkg.sv =====
// Shared types and constants for the quarter-wave sine PWM generator
package qwsp_pkg;

  // Field widths
  localparam int TICK_W    = 64;
  localparam int TBL_IDX_W = 6;
  localparam int TBL_VAL_W = 10;
  localparam int PWM_W     = 10;
  localparam int QUAD_W    = 2;
  localparam int FREQ_W    = 16;
  localparam int PER_W     = 24;

  // Arithmetic constants
  localparam logic [FREQ_W-1:0] FREQ_RESET  = 16'd60000;
  localparam logic [PER_W-1:0]  PERIOD_NUM  = 24'd10000000;
  localparam int                PHASE_SCALE = 128;
  localparam int                PHASE_SHIFT = 7;
  localparam logic [PWM_W:0]    PWM_MID_LO  = 11'd511;
  localparam logic [PWM_W:0]    PWM_MID_HI  = 11'd512;
  localparam logic [PWM_W:0]    PWM_MAX     = 11'd1023;

  localparam int TABLE_SIZE_DEF = 50;

  // Item kinds
  localparam logic KIND_SAMPLE   = 1'b0;
  localparam logic KIND_TABLE_WR = 1'b1;

  // Quadrant codes
  localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
  localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
  localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
  localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

  typedef enum logic {
    DIV_PERIOD,
    DIV_FACTOR
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WAIT_PER,
    ST_FAC_START,
    ST_WRAP,
    ST_WAIT_FAC,
    ST_MUL,
    ST_FOLD,
    ST_READ,
    ST_EMIT
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic     in_ready;
    logic     tbl_wr;
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_period;
    logic     calc_elapsed;
    logic     wrap;
    logic     cap_factor;
    logic     mul;
    logic     fold;
    logic     rd;
    logic     emit;
  } qwsp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_table;
    logic div_done;
    logic out_busy;
  } qwsp_stat_t;

endpackage

// ===== rtl/qwsp_if.sv =====
// Handshake channel interfaces for sample/table items and PWM results
interface qwsp_in_if;
  import qwsp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [TICK_W-1:0]    tick_now;
  logic [TBL_IDX_W-1:0] table_index;
  logic [TBL_VAL_W-1:0] table_value;

  modport source (output valid, kind, tick_now, table_index, table_value, input ready);
  modport sink   (input valid, kind, tick_now, table_index, table_value, output ready);
endinterface

interface qwsp_res_if;
  import qwsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [PWM_W-1:0]  pwm_value;
  logic [QUAD_W-1:0] quadrant;

  modport source (output valid, pwm_value, quadrant, input ready);
  modport sink   (input valid, pwm_value, quadrant, output ready);
endinterface

// ===== rtl/qwsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module qwsp_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/qwsp_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle
`include "assert_macros.svh"

module qwsp_div #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  // Control: count iterations, pulse done on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

  `QWSP_ASSERT_NXT(a_div_done_pulse, clk, rst, done, !done)
  `QWSP_ASSERT_IMP(a_div_done_idle, clk, rst, done, !busy)

endmodule

// ===== rtl/qwsp_dp.sv =====
// Datapath: period and phase arithmetic, sine table, output register
`include "assert_macros.svh"

module qwsp_dp #(
  parameter int TABLE_SIZE = qwsp_pkg::TABLE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [qwsp_pkg::FREQ_W-1:0] cfg_wr_data,
  input  qwsp_pkg::qwsp_cmd_t        cmd,
  output qwsp_pkg::qwsp_stat_t       stat,
  qwsp_in_if.sink                    in_ch,
  qwsp_res_if.source                 out_ch
);
  import qwsp_pkg::*;

  localparam int AW    = $clog2(TABLE_SIZE);
  localparam int CW    = ((AW > TBL_IDX_W) ? AW : TBL_IDX_W) + 1;
  localparam int FAC_W = $clog2(TABLE_SIZE * 4 * PHASE_SCALE + 1);
  localparam int IDX_W = $clog2(4 * TABLE_SIZE);
  localparam int SW    = IDX_W + 2;
  localparam int PRD_W = FAC_W + PER_W;

  // Configuration and latched item
  logic [FREQ_W-1:0] freq;
  logic [TICK_W-1:0] tick;
  logic [TICK_W-1:0] period_start;

  // Arithmetic registers
  logic [PER_W-1:0]  period;
  logic [FAC_W-1:0]  factor;
  logic [TICK_W-1:0] elapsed;
  logic [PER_W-1:0]  el_w;
  logic [PRD_W-1:0]  prod;
  logic [QUAD_W-1:0] quad;
  logic [AW-1:0]     fold_addr;

  // Table
  logic [TABLE_SIZE-1:0] tbl_valid;
  logic                  rd_valid;
  logic [TBL_VAL_W-1:0]  ram_q;
  logic                  tbl_we;
  logic [CW-1:0]         wr_idx;

  // Divider
  logic [PER_W-1:0] div_dividend;
  logic [PER_W-1:0] div_divisor;
  logic [PER_W-1:0] div_quo;
  logic             div_done;

  // Output register
  logic              out_valid;
  logic [PWM_W-1:0]  out_pwm;
  logic [QUAD_W-1:0] out_quad;

  // Combinational helpers
  logic [FREQ_W-1:0]       freq_eff;
  logic                    late_one;
  logic                    late_two;
  logic [IDX_W-1:0]        idx;
  logic [PER_W+1:0]        per3;
  logic [PER_W-1:0]        q1_lim;
  logic [PER_W-1:0]        q2_lim;
  logic [PER_W-1:0]        q3_lim;
  logic signed [SW-1:0]    idx_s;
  logic signed [SW-1:0]    folded;
  logic [QUAD_W-1:0]       quad_next;
  logic [AW-1:0]           addr_next;
  logic [TBL_VAL_W-1:0]    entry;
  logic [PWM_W:0]          sum_lo;
  logic [PWM_W:0]          diff_hi;
  logic [PWM_W-1:0]        pwm_next;

  // Frequency register
  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= FREQ_RESET;
    end else if (cfg_wr_en) begin
      freq <= cfg_wr_data;
    end
  end

  // Status toward the controller
  assign in_ch.ready    = cmd.in_ready;
  assign stat.in_valid  = in_ch.valid;
  assign stat.in_table  = (in_ch.kind == KIND_TABLE_WR);
  assign stat.div_done  = div_done;
  assign stat.out_busy  = out_valid && !out_ch.ready;

  // Divider operand select
  always_comb begin
    freq_eff = (freq == '0) ? FREQ_W'(1) : freq;
    unique case (cmd.div_sel)
      DIV_PERIOD: begin
        div_dividend = PERIOD_NUM;
        div_divisor  = PER_W'(freq_eff);
      end
      DIV_FACTOR: begin
        div_dividend = PER_W'(TABLE_SIZE * 4 * PHASE_SCALE);
        div_divisor  = period;
      end
      default: begin
        div_dividend = PERIOD_NUM;
        div_divisor  = PER_W'(freq_eff);
      end
    endcase
  end

  qwsp_div #(.W(PER_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Table write: drop indexes past the end
  assign wr_idx = CW'(in_ch.table_index);
  assign tbl_we = cmd.tbl_wr && (wr_idx < CW'(TABLE_SIZE));

  qwsp_ram #(.WIDTH(TBL_VAL_W), .DEPTH(TABLE_SIZE)) u_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (wr_idx[AW-1:0]),
    .wdata (in_ch.table_value),
    .re    (cmd.rd),
    .raddr (fold_addr),
    .rdata (ram_q)
  );

  // Entry valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
    end else if (tbl_we) begin
      tbl_valid[wr_idx[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_valid <= tbl_valid[fold_addr];
    end
  end

  // Period start tracking
  assign late_one = elapsed >= TICK_W'(period);
  assign late_two = elapsed >= TICK_W'({period, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      period_start <= '0;
    end else if (cmd.wrap && late_one) begin
      if (late_two) begin
        period_start <= tick;
      end else begin
        period_start <= period_start + TICK_W'(period);
      end
    end
  end

  // Phase arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick <= in_ch.tick_now;
    end
    if (cmd.cap_period) begin
      period <= div_quo;
    end
    if (cmd.calc_elapsed) begin
      elapsed <= tick - period_start;
    end
    if (cmd.wrap) begin
      if (!late_one) begin
        el_w <= elapsed[PER_W-1:0];
      end else if (late_two) begin
        el_w <= '0;
      end else begin
        el_w <= elapsed[PER_W-1:0] - period;
      end
    end
    if (cmd.cap_factor) begin
      factor <= div_quo[FAC_W-1:0];
    end
    if (cmd.mul) begin
      prod <= PRD_W'(factor) * PRD_W'(el_w);
    end
    if (cmd.fold) begin
      quad      <= quad_next;
      fold_addr <= addr_next;
    end
  end

  // Quadrant and fold into the quarter table
  always_comb begin
    idx    = prod[PHASE_SHIFT +: IDX_W];
    idx_s  = $signed(SW'(idx));
    per3   = {2'b00, period} + {1'b0, period, 1'b0};
    q1_lim = period >> 2;
    q2_lim = period >> 1;
    q3_lim = per3[PER_W+1:2];
    priority if (el_w >= q3_lim) begin
      quad_next = QUAD_3;
      folded    = $signed(SW'(4 * TABLE_SIZE - 1)) - idx_s;
    end else if (el_w >= q2_lim) begin
      quad_next = QUAD_2;
      folded    = idx_s - $signed(SW'(2 * TABLE_SIZE));
    end else if (el_w >= q1_lim) begin
      quad_next = QUAD_1;
      folded    = $signed(SW'(2 * TABLE_SIZE - 1)) - idx_s;
    end else begin
      quad_next = QUAD_0;
      folded    = idx_s;
    end
    // Clamp to the table range
    priority if (folded < $signed(SW'(0))) begin
      addr_next = '0;
    end else if (folded > $signed(SW'(TABLE_SIZE - 1))) begin
      addr_next = AW'(TABLE_SIZE - 1);
    end else begin
      addr_next = folded[AW-1:0];
    end
  end

  // PWM value with saturation
  always_comb begin
    entry   = rd_valid ? ram_q : '0;
    sum_lo  = PWM_MID_LO + (PWM_W + 1)'(entry);
    diff_hi = PWM_MID_HI - (PWM_W + 1)'(entry);
    if (quad == QUAD_0 || quad == QUAD_1) begin
      pwm_next = (sum_lo > PWM_MAX) ? PWM_MAX[PWM_W-1:0] : sum_lo[PWM_W-1:0];
    end else begin
      pwm_next = ((PWM_W + 1)'(entry) > PWM_MID_HI) ? '0 : diff_hi[PWM_W-1:0];
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pwm  <= pwm_next;
      out_quad <= quad;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.pwm_value = out_pwm;
  assign out_ch.quadrant  = out_quad;

  `QWSP_ASSERT_NXT(a_wrap_in_period, clk, rst, cmd.wrap, el_w < period)
  `QWSP_ASSERT_IMP(a_rd_in_table, clk, rst, cmd.rd, fold_addr <= AW'(TABLE_SIZE - 1))

endmodule

// ===== rtl/qwsp_ctl.sv =====
// Controller: sequences accept, divisions, wrap, multiply, fold, read, emit
`include "assert_macros.svh"

module qwsp_ctl (
  input  logic                 clk,
  input  logic                 rst,
  input  qwsp_pkg::qwsp_stat_t stat,
  output qwsp_pkg::qwsp_cmd_t  cmd
);
  import qwsp_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       div_waiting;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_PERIOD;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          if (stat.in_table) begin
            cmd.tbl_wr = 1'b1;
          end else begin
            cmd.load      = 1'b1;
            cmd.div_start = 1'b1;
            state_next    = ST_WAIT_PER;
          end
        end
      end
      ST_WAIT_PER: begin
        if (stat.div_done) begin
          cmd.cap_period = 1'b1;
          state_next     = ST_FAC_START;
        end
      end
      ST_FAC_START: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel      = DIV_FACTOR;
        cmd.calc_elapsed = 1'b1;
        state_next       = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.div_sel = DIV_FACTOR;
        cmd.wrap    = 1'b1;
        state_next  = ST_WAIT_FAC;
      end
      ST_WAIT_FAC: begin
        cmd.div_sel = DIV_FACTOR;
        if (stat.div_done) begin
          cmd.cap_factor = 1'b1;
          state_next     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Divider finishes only while one of the wait states holds
  assign div_waiting = (state == ST_WAIT_PER) || (state == ST_WAIT_FAC);

  `QWSP_ASSERT_IMP(a_done_when_waiting, clk, rst, stat.div_done, div_waiting)

endmodule

// ===== rtl/quarter_wave_sine_pwm_generator.sv =====
// A sample item is taken only in the idle state; the next one waits until its result is emitted.
// Its path holds two passes of the shared radix-2 divider (period, then phase factor).
// A table-write item is written in the cycle it is taken and gives no result.
// A result waits in the output register; a sample finishing behind it stalls until it is taken.
// Reset (rst, synchronous): frequency 60000 mHz, period start 0, all table entries read as zero.
module quarter_wave_sine_pwm_generator #(
  parameter int TABLE_SIZE = qwsp_pkg::TABLE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [qwsp_pkg::FREQ_W-1:0] cfg_wr_data,
  qwsp_in_if.sink                     in_ch,
  qwsp_res_if.source                  out_ch
);
  import qwsp_pkg::*;

  qwsp_cmd_t  cmd;
  qwsp_stat_t stat;

  qwsp_ctl u_ctl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  qwsp_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule
